// ===== rtl/core/slnl_pkg.sv =====
// ----------------------------------------------------------------------------
// slnl_pkg
// Shared types and constants for the serial display-link nibble transmitter.
// ----------------------------------------------------------------------------
package slnl_pkg;

  // register field widths
  localparam int HALF_W    = 8;
  localparam int GAP_REG_W = 20;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 20;

  // default width of the elapsed-tick counter
  localparam int GAP_BITS_DEF = 20;

  // register reset values
  localparam logic [HALF_W-1:0]    HALF_RST = 8'd4;
  localparam logic [GAP_REG_W-1:0] GAP_RST  = '0;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_BIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_GAP = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CMD_GAP  = 2'd2;

  // wire byte constants
  localparam logic [7:0] SYNC_COMMAND   = 8'hF8;
  localparam logic [7:0] SYNC_DATA_KIND = 8'hFA;
  localparam logic [7:0] HIGH_MASK      = 8'hF0;
  localparam logic [3:0] BITS_PER_BYTE  = 4'd8;

  // transfer stage
  typedef enum logic [2:0] {
    ST_IDLE = 3'd0,
    ST_SYNC = 3'd1,
    ST_HIGH = 3'd2,
    ST_WAIT = 3'd3,
    ST_LOW  = 3'd4
  } stage_t;

  // configuration registers as seen by the engine
  typedef struct packed {
    logic [HALF_W-1:0]    half_bit_ticks;
    logic [GAP_REG_W-1:0] sync_gap_ticks;
    logic [GAP_REG_W-1:0] cmd_gap_ticks;
  } cfg_t;

  // one input item: one time-base tick
  typedef struct packed {
    logic       offer_valid;
    logic [7:0] byte_value;
    logic       is_data;
    logic       first_of_group;
    logic       abort;
  } in_item_t;

  // one result item: pin levels after the tick
  typedef struct packed {
    logic clock_line;
    logic data_line;
    logic byte_taken;
    logic busy_res;
  } out_item_t;

endpackage

// ===== rtl/core/slnl_ifs.sv =====
// ----------------------------------------------------------------------------
// slnl_ifs
// Valid/ready channel interfaces for tick items and result items.
// ----------------------------------------------------------------------------
interface slnl_in_if;
  logic                 valid;
  logic                 ready;
  slnl_pkg::in_item_t   data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface slnl_out_if;
  logic                 valid;
  logic                 ready;
  slnl_pkg::out_item_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/slnl_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// slnl_cfg_regs
// Write-only configuration registers: half bit period and the two gaps.
// ----------------------------------------------------------------------------
module slnl_cfg_regs (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [slnl_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [slnl_pkg::CFG_DAT_W-1:0]     cfg_wdata,
  output slnl_pkg::cfg_t                     cfg
);

  logic [slnl_pkg::HALF_W-1:0]    half_r;
  logic [slnl_pkg::GAP_REG_W-1:0] sync_gap_r;
  logic [slnl_pkg::GAP_REG_W-1:0] cmd_gap_r;

  // register writes, indexes outside the list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_r     <= slnl_pkg::HALF_RST;
      sync_gap_r <= slnl_pkg::GAP_RST;
      cmd_gap_r  <= slnl_pkg::GAP_RST;
    end else if (cfg_we) begin
      if (cfg_index == slnl_pkg::CFG_HALF_BIT) begin
        half_r <= cfg_wdata[slnl_pkg::HALF_W-1:0];
      end
      if (cfg_index == slnl_pkg::CFG_SYNC_GAP) begin
        sync_gap_r <= cfg_wdata[slnl_pkg::GAP_REG_W-1:0];
      end
      if (cfg_index == slnl_pkg::CFG_CMD_GAP) begin
        cmd_gap_r <= cfg_wdata[slnl_pkg::GAP_REG_W-1:0];
      end
    end
  end

  assign cfg.half_bit_ticks = half_r;
  assign cfg.sync_gap_ticks = sync_gap_r;
  assign cfg.cmd_gap_ticks  = cmd_gap_r;

endmodule

// ===== rtl/core/slnl_in_stage.sv =====
// ----------------------------------------------------------------------------
// slnl_in_stage
// Input register for tick items; refills in the cycle it is drained.
// ----------------------------------------------------------------------------
module slnl_in_stage (
  input  logic               clk,
  input  logic               rst_n,
  slnl_in_if.sink            in_chan,
  input  logic               pop,
  output logic               item_valid,
  output slnl_pkg::in_item_t item
);

  logic               valid_r;
  logic               valid_nxt;
  slnl_pkg::in_item_t item_r;
  logic               load;

  // accept when empty or when the held item moves on
  assign in_chan.ready = !valid_r || pop;
  assign load          = in_chan.valid && in_chan.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (pop) begin
      valid_nxt = 1'b0;
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= in_chan.data;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

// ===== rtl/core/slnl_engine.sv =====
// ----------------------------------------------------------------------------
// slnl_engine
// Per-tick transmitter state update and the result register.
// ----------------------------------------------------------------------------
module slnl_engine #(
  parameter int GAP_BITS = slnl_pkg::GAP_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  slnl_pkg::cfg_t     cfg,
  input  logic               item_valid,
  input  slnl_pkg::in_item_t item,
  output logic               pop,
  slnl_out_if.source         out_chan
);

  localparam int CMP_W = (GAP_BITS > slnl_pkg::GAP_REG_W) ? GAP_BITS : slnl_pkg::GAP_REG_W;
  localparam logic [GAP_BITS-1:0] ELAPSED_MAX = {GAP_BITS{1'b1}};
  localparam logic [GAP_BITS-1:0] ELAPSED_ONE = GAP_BITS'(1);

  // transmitter state
  logic [7:0]            shift_r,   shift_nxt;
  logic [3:0]            bits_r,    bits_nxt;
  logic [7:0]            half_r,    half_nxt;
  logic                  phase_r,   phase_nxt;
  slnl_pkg::stage_t      stage_r,   stage_nxt;
  logic [7:0]            held_r,    held_nxt;
  logic                  sync_r,    sync_nxt;
  logic [GAP_BITS-1:0]   elapsed_r, elapsed_nxt;
  logic                  clk_lvl_r, clk_lvl_nxt;
  logic                  dat_lvl_r, dat_lvl_nxt;

  // result register
  logic                  out_valid_r, out_valid_nxt;
  slnl_pkg::out_item_t   out_item_r,  out_item_nxt;

  logic [GAP_BITS-1:0]        elapsed_inc;
  logic [slnl_pkg::GAP_REG_W-1:0] gap_sel;
  logic                       gap_ok;
  logic                       taken;
  logic                       do_load;
  logic [7:0]                 load_val;
  slnl_pkg::stage_t           load_stage;
  logic [3:0]                 bits_dec;

  // one tick is processed whenever the result register can take its result
  assign pop = item_valid && (!out_valid_r || out_chan.ready);

  // saturating elapsed counter and gap check
  assign elapsed_inc = (elapsed_r == ELAPSED_MAX) ? elapsed_r : elapsed_r + ELAPSED_ONE;
  assign gap_sel     = sync_r ? cfg.sync_gap_ticks : cfg.cmd_gap_ticks;
  assign gap_ok      = (CMP_W'(elapsed_inc) >= CMP_W'(gap_sel)) || (elapsed_inc == ELAPSED_MAX);
  assign bits_dec    = (bits_r != 4'd0) ? bits_r - 4'd1 : 4'd0;

  // next state for one tick
  always_comb begin
    shift_nxt   = shift_r;
    bits_nxt    = bits_r;
    half_nxt    = half_r;
    phase_nxt   = phase_r;
    stage_nxt   = stage_r;
    held_nxt    = held_r;
    sync_nxt    = sync_r;
    elapsed_nxt = elapsed_inc;
    clk_lvl_nxt = clk_lvl_r;
    dat_lvl_nxt = dat_lvl_r;
    taken       = 1'b0;
    do_load     = 1'b0;
    load_val    = 8'd0;
    load_stage  = slnl_pkg::ST_IDLE;

    if (item.abort) begin
      clk_lvl_nxt = 1'b0;
      dat_lvl_nxt = 1'b0;
      stage_nxt   = slnl_pkg::ST_IDLE;
      bits_nxt    = 4'd0;
      half_nxt    = 8'd0;
      phase_nxt   = 1'b0;
    end else begin
      unique case (stage_r)
        slnl_pkg::ST_SYNC, slnl_pkg::ST_HIGH, slnl_pkg::ST_LOW: begin
          // bit engine: count a half period, then toggle the clock
          if (half_r < cfg.half_bit_ticks) begin
            half_nxt = half_r + 8'd1;
          end else begin
            half_nxt = 8'd1;
            if (!phase_r) begin
              phase_nxt   = 1'b1;
              clk_lvl_nxt = 1'b1;
            end else begin
              clk_lvl_nxt = 1'b0;
              phase_nxt   = 1'b0;
              shift_nxt   = {shift_r[6:0], 1'b0};
              bits_nxt    = bits_dec;
              if (bits_dec == 4'd0) begin
                // wire byte finished
                if (stage_r == slnl_pkg::ST_SYNC) begin
                  do_load    = 1'b1;
                  load_val   = held_r & slnl_pkg::HIGH_MASK;
                  load_stage = slnl_pkg::ST_HIGH;
                end else if (stage_r == slnl_pkg::ST_HIGH) begin
                  stage_nxt  = slnl_pkg::ST_WAIT;
                  do_load    = gap_ok;
                  load_val   = {held_r[3:0], 4'd0};
                  load_stage = slnl_pkg::ST_LOW;
                end else begin
                  stage_nxt   = slnl_pkg::ST_IDLE;
                  elapsed_nxt = '0;
                end
              end else begin
                dat_lvl_nxt = shift_r[6];
              end
            end
          end
        end
        slnl_pkg::ST_WAIT: begin
          do_load    = gap_ok;
          load_val   = {held_r[3:0], 4'd0};
          load_stage = slnl_pkg::ST_LOW;
        end
        default: begin
          // idle and unused codes take an offered byte
          stage_nxt = slnl_pkg::ST_IDLE;
          if (item.offer_valid) begin
            taken    = 1'b1;
            held_nxt = item.byte_value;
            sync_nxt = item.first_of_group;
            do_load  = 1'b1;
            if (item.first_of_group) begin
              load_val   = item.is_data ? slnl_pkg::SYNC_DATA_KIND : slnl_pkg::SYNC_COMMAND;
              load_stage = slnl_pkg::ST_SYNC;
            end else begin
              load_val   = item.byte_value & slnl_pkg::HIGH_MASK;
              load_stage = slnl_pkg::ST_HIGH;
            end
          end
        end
      endcase
    end

    // start a wire byte with its first setup half
    if (do_load) begin
      shift_nxt   = load_val;
      bits_nxt    = slnl_pkg::BITS_PER_BYTE;
      half_nxt    = 8'd1;
      phase_nxt   = 1'b0;
      clk_lvl_nxt = 1'b0;
      dat_lvl_nxt = load_val[7];
      stage_nxt   = load_stage;
    end

    out_item_nxt.clock_line = clk_lvl_nxt;
    out_item_nxt.data_line  = dat_lvl_nxt;
    out_item_nxt.byte_taken = taken;
    out_item_nxt.busy_res   = (stage_nxt != slnl_pkg::ST_IDLE);
  end

  // result valid
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (pop) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // state and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_r     <= '0;
      bits_r      <= '0;
      half_r      <= '0;
      phase_r     <= 1'b0;
      stage_r     <= slnl_pkg::ST_IDLE;
      held_r      <= '0;
      sync_r      <= 1'b0;
      elapsed_r   <= '0;
      clk_lvl_r   <= 1'b0;
      dat_lvl_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (pop) begin
        shift_r   <= shift_nxt;
        bits_r    <= bits_nxt;
        half_r    <= half_nxt;
        phase_r   <= phase_nxt;
        stage_r   <= stage_nxt;
        held_r    <= held_nxt;
        sync_r    <= sync_nxt;
        elapsed_r <= elapsed_nxt;
        clk_lvl_r <= clk_lvl_nxt;
        dat_lvl_r <= dat_lvl_nxt;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (pop) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_chan.valid = out_valid_r;
  assign out_chan.data  = out_item_r;

endmodule

// ===== rtl/core/serial_lcd_nibble_link_top.sv =====
// A tick item moves from the input register via the state update into the result register.
// One tick item per cycle unless out_chan stalls; the input register refills as it drains.
// Pace is set by the single state update between input and result registers.
// Reset (rst_n low, synchronous): idle, lines low, counters zero, half period 4,
// both gaps 0; no items held in either register.
// ----------------------------------------------------------------------------
// serial_lcd_nibble_link_top
// Serial display-link transmitter: sync byte, nibble split, gap waits.
// ----------------------------------------------------------------------------
module serial_lcd_nibble_link_top #(
  parameter int GAP_BITS = slnl_pkg::GAP_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  slnl_in_if.sink                        in_chan,
  slnl_out_if.source                     out_chan,
  input  logic                           cfg_we,
  input  logic [slnl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [slnl_pkg::CFG_DAT_W-1:0] cfg_wdata
);

  slnl_pkg::cfg_t     cfg;
  logic               item_valid;
  slnl_pkg::in_item_t item;
  logic               pop;

  // configuration registers
  slnl_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // input register
  slnl_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_chan),
    .pop        (pop),
    .item_valid (item_valid),
    .item       (item)
  );

  // tick engine and result register
  slnl_engine #(
    .GAP_BITS (GAP_BITS)
  ) u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .item_valid (item_valid),
    .item       (item),
    .pop        (pop),
    .out_chan   (out_chan)
  );

endmodule
